FILE: hdl/vse_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the hull test for the voxel surface extractor
// no dependencies; used by vse_window and voxel_surface_extract_26

package vse_pkg;

  // default largest side of the volume
  localparam int DEF_MAX_SIZE = 64;
  // size register width, reset value and smallest side in use
  localparam int GRID_W = 7;
  localparam int GRID_RESET = 64;
  localparam int MIN_SIZE = 3;
  // running hull count width
  localparam int COUNT_W = 19;
  // 3x3x3 window, bit index is dk*9 + di*3 + dj with offsets shifted by one
  localparam int WIN_BITS = 27;
  localparam int CENTER = 13;

  // center voxel sits on a face of the volume
  typedef struct packed {
    logic i_lo;
    logic i_hi;
    logic j_lo;
    logic j_hi;
    logic k_lo;
    logic k_hi;
  } vse_bound_t;

  // control that travels with each voxel through the window pipeline
  typedef struct packed {
    logic       emit;
    logic       last;
    vse_bound_t bound;
  } vse_tag_t;

  // one result
  typedef struct packed {
    logic               hull;
    logic               last;
    logic [COUNT_W-1:0] count;
  } vse_result_t;

  // occupied center with at least one empty or outside neighbor
  function automatic logic hull_of(logic [WIN_BITS-1:0] win, vse_bound_t b);
    logic any;
    logic oob;
    any = 1'b0;
    for (int dk = 0; dk < 3; dk++) begin
      for (int di = 0; di < 3; di++) begin
        for (int dj = 0; dj < 3; dj++) begin
          oob = (di == 0 && b.i_lo) || (di == 2 && b.i_hi) ||
                (dj == 0 && b.j_lo) || (dj == 2 && b.j_hi) ||
                (dk == 0 && b.k_lo) || (dk == 2 && b.k_hi);
          if ((dk * 9 + di * 3 + dj) != CENTER &&
              (oob || !win[dk * 9 + di * 3 + dj])) begin
            any = 1'b1;
          end
        end
      end
    end
    return win[CENTER] && any;
  endfunction

endpackage

FILE: hdl/voxel_surface_extract_26.sv
`timescale 1ns / 1ps
// top level of the 26-neighbor hull extractor: sequencing, hull test, output buffer
// depends on vse_pkg and vse_window

// Voxels enter on the input channel (in_valid / in_stall), one occupancy bit per
// request, raster order with the column index fastest. A request with flush set
// carries no voxel and drains one pending result once the volume is complete.
// Each result (is_hull, is_last, hull_count) leaves on the output channel
// (out_valid / out_stall). The result for a voxel is triggered by the request
// that arrives one plane plus one row plus one voxel later in the stream, or by
// a drain request; it passes window stages a, b and c, then the output buffer.
// One request per cycle is sustained while in_stall is low; the window pipeline
// and both delay lines advance per stored voxel or drain; plane line 2**(2*CW) x 6.
// Results go to a two-entry output buffer; while the receiver stalls the block
// keeps accepting until that buffer is full, then raises in_stall.
// cfg_wen writes grid_size (clamped to 3..MAX_SIZE) and restarts the volume;
// the user must write it only while the block is idle; it is not enforced.
// Reset (rst, synchronous) empties the pipeline and buffer, clears the counters
// and sets the side to min(64, MAX_SIZE). The delay lines need no clearing: stale
// entries only ever stand for neighbors outside the volume, which are masked.

module voxel_surface_extract_26 #(
  parameter int MAX_SIZE = vse_pkg::DEF_MAX_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [vse_pkg::GRID_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        occupied,
  input  logic                        flush,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_hull,
  output logic                        is_last,
  output logic [vse_pkg::COUNT_W-1:0] hull_count
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int SIDE_RESET =
    (vse_pkg::GRID_RESET > MAX_SIZE) ? MAX_SIZE : vse_pkg::GRID_RESET;
  localparam logic [CW-1:0] SIDE_LAST_RESET = CW'(SIDE_RESET - 1);

  // configuration
  logic [CW-1:0] side_last;
  logic [CW-1:0] side_last_next;

  // input and output raster positions
  logic [CW-1:0] ii, ij, ik;
  logic [CW-1:0] ii_next, ij_next, ik_next;
  logic [CW-1:0] oi, oj, ok;
  logic [CW-1:0] oi_next, oj_next, ok_next;
  logic          in_done, in_done_next;
  logic          lead, lead_next;

  // request classification
  logic go;
  logic accept;
  logic wr;
  logic drain;
  logic at111;
  logic in_end;
  logic out_end;
  logic emit;
  logic last;
  vse_pkg::vse_tag_t tag_in;

  // window
  logic                         win_valid;
  vse_pkg::vse_tag_t            win_tag;
  logic [vse_pkg::WIN_BITS-1:0] window;

  // result and count
  logic                         push;
  logic                         hull;
  logic [vse_pkg::COUNT_W-1:0]  hull_total;
  logic [vse_pkg::COUNT_W-1:0]  count_next;
  vse_pkg::vse_result_t         res;

  // output buffer
  vse_pkg::vse_result_t head, head_next;
  vse_pkg::vse_result_t skid, skid_next;
  logic [1:0]           cnt, cnt_next;
  logic                 pop;

  // clamp the written size
  always_comb begin
    if (cfg_wdata < vse_pkg::GRID_W'(vse_pkg::MIN_SIZE)) begin
      side_last_next = CW'(vse_pkg::MIN_SIZE - 1);
    end else if (int'(cfg_wdata) > MAX_SIZE) begin
      side_last_next = CW'(MAX_SIZE - 1);
    end else begin
      side_last_next = CW'(cfg_wdata - 1'b1);
    end
  end

  // pipeline moves unless the output buffer is full
  assign go       = (cnt != 2'd2);
  assign in_stall = !go;
  assign accept   = in_valid && !in_stall;

  // a voxel is stored until the volume is complete, then every request drains
  assign wr      = accept && !flush && !in_done;
  assign drain   = accept && in_done;
  assign at111   = (ii == CW'(1)) && (ij == CW'(1)) && (ik == CW'(1));
  assign in_end  = (ii == side_last) && (ij == side_last) && (ik == side_last);
  assign out_end = (oi == side_last) && (oj == side_last) && (ok == side_last);
  assign emit    = (wr && (lead || at111)) || drain;
  assign last    = emit && out_end;

  // tag for the voxel whose neighborhood this request completes
  always_comb begin
    tag_in.emit       = emit;
    tag_in.last       = out_end;
    tag_in.bound.i_lo = (oi == '0);
    tag_in.bound.i_hi = (oi == side_last);
    tag_in.bound.j_lo = (oj == '0);
    tag_in.bound.j_hi = (oj == side_last);
    tag_in.bound.k_lo = (ok == '0);
    tag_in.bound.k_hi = (ok == side_last);
  end

  // position counters
  always_comb begin
    ii_next      = ii;
    ij_next      = ij;
    ik_next      = ik;
    oi_next      = oi;
    oj_next      = oj;
    ok_next      = ok;
    in_done_next = in_done;
    lead_next    = lead;
    if (wr) begin
      if (ik == side_last) begin
        ik_next = '0;
        if (ij == side_last) begin
          ij_next = '0;
          ii_next = (ii == side_last) ? '0 : ii + 1'b1;
        end else begin
          ij_next = ij + 1'b1;
        end
      end else begin
        ik_next = ik + 1'b1;
      end
      if (in_end) begin
        in_done_next = 1'b1;
      end
      if (at111) begin
        lead_next = 1'b1;
      end
    end
    if (emit) begin
      if (ok == side_last) begin
        ok_next = '0;
        if (oj == side_last) begin
          oj_next = '0;
          oi_next = (oi == side_last) ? '0 : oi + 1'b1;
        end else begin
          oj_next = oj + 1'b1;
        end
      end else begin
        ok_next = ok + 1'b1;
      end
    end
    // end of volume or a size write starts over
    if (last || cfg_wen) begin
      ii_next      = '0;
      ij_next      = '0;
      ik_next      = '0;
      oi_next      = '0;
      oj_next      = '0;
      ok_next      = '0;
      in_done_next = 1'b0;
      lead_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_last <= SIDE_LAST_RESET;
      ii        <= '0;
      ij        <= '0;
      ik        <= '0;
      oi        <= '0;
      oj        <= '0;
      ok        <= '0;
      in_done   <= 1'b0;
      lead      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        side_last <= side_last_next;
      end
      ii      <= ii_next;
      ij      <= ij_next;
      ik      <= ik_next;
      oi      <= oi_next;
      oj      <= oj_next;
      ok      <= ok_next;
      in_done <= in_done_next;
      lead    <= lead_next;
    end
  end

  // delay lines and window
  vse_window #(
    .MAX_SIZE (MAX_SIZE)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_wen),
    .go        (go),
    .side_last (side_last),
    .push      (wr || drain),
    .vox       (wr && occupied),
    .tag_in    (tag_in),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .window    (window)
  );

  // hull test and running count
  assign push       = go && win_valid && win_tag.emit;
  assign hull       = vse_pkg::hull_of(window, win_tag.bound);
  assign count_next = hull_total + vse_pkg::COUNT_W'(hull);

  always_comb begin
    res.hull  = hull;
    res.last  = win_tag.last;
    res.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      hull_total <= '0;
    end else if (push) begin
      hull_total <= win_tag.last ? '0 : count_next;
    end
  end

  // two-entry output buffer
  assign pop = (cnt != 2'd0) && !out_stall;

  always_comb begin
    head_next = head;
    skid_next = skid;
    cnt_next  = cnt;
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          head_next = res;
        end else begin
          skid_next = res;
        end
        cnt_next = cnt + 1'b1;
      end
      2'b01: begin
        head_next = skid;
        cnt_next  = cnt - 1'b1;
      end
      2'b11: begin
        if (cnt == 2'd2) begin
          head_next = skid;
          skid_next = res;
        end else begin
          head_next = res;
        end
      end
      2'b00: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    skid <= skid_next;
  end

  assign out_valid  = (cnt != 2'd0);
  assign is_hull    = head.hull;
  assign is_last    = head.last;
  assign hull_count = head.count;

`ifndef NO_ASSERTIONS
  // the volume cannot be complete before results have started
  a_done_has_lead: assert property (@(posedge clk) disable iff (rst)
    in_done |-> lead)
    else $error("volume complete without results started");

  // no result position moves before the first result is due
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    !lead |-> (oi == '0 && oj == '0 && ok == '0))
    else $error("output position moved before first result");

  // the count starts over after the last result of a volume
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (push && win_tag.last) |=> (hull_total == '0))
    else $error("hull count not cleared after last result");
`endif

endmodule

FILE: hdl/vse_window.sv
`timescale 1ns / 1ps
// row and plane delay lines and the 3x3x3 voxel window, three register stages
// depends on vse_pkg

module vse_window #(
  parameter int MAX_SIZE = vse_pkg::DEF_MAX_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clr,
  input  logic                            go,
  input  logic [$clog2(MAX_SIZE)-1:0]     side_last,
  input  logic                            push,
  input  logic                            vox,
  input  vse_pkg::vse_tag_t               tag_in,
  output logic                            win_valid,
  output vse_pkg::vse_tag_t               win_tag,
  output logic [vse_pkg::WIN_BITS-1:0]    window
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int PDEPTH = 1 << (2 * CW);

  // row line holds {x[q], x[q-n]}, plane line holds {row[q], row[q-n*n]}
  logic [1:0] row_mem [0:MAX_SIZE-1];
  logic [5:0] plane_mem [0:PDEPTH-1];

  // circular slot pointer, pk has period n, {pj, pk} has period n*n
  logic [CW-1:0] pk;
  logic [CW-1:0] pj;

  // stage a: incoming voxel and row line read
  logic              a_valid;
  logic              a_vox;
  vse_pkg::vse_tag_t a_tag;
  logic [CW-1:0]     a_pk;
  logic [CW-1:0]     a_pj;
  logic [1:0]        a_rd;
  logic [2:0]        a_row;

  // stage b: row column and plane line read
  logic              b_valid;
  logic [2:0]        b_row;
  vse_pkg::vse_tag_t b_tag;
  logic [2*CW-1:0]   b_ptr;
  logic [5:0]        b_rd;
  logic [8:0]        b_col;

  // stage c: last three plane columns
  logic              c_valid;
  vse_pkg::vse_tag_t c_tag;
  logic [8:0]        col [0:2];

  // slot pointer advances once per voxel entering the window
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pk <= '0;
      pj <= '0;
    end else if (go && push) begin
      if (pk == side_last) begin
        pk <= '0;
        pj <= (pj == side_last) ? '0 : pj + 1'b1;
      end else begin
        pk <= pk + 1'b1;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (go) begin
      a_valid <= push;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // stage a payload and row line read
  always_ff @(posedge clk) begin
    if (go && push) begin
      a_vox <= vox;
      a_tag <= tag_in;
      a_pk  <= pk;
      a_pj  <= pj;
      a_rd  <= row_mem[pk];
    end
  end

  // row line write, one request behind the read
  always_ff @(posedge clk) begin
    if (go && a_valid) begin
      row_mem[a_pk] <= {a_vox, a_rd[1]};
    end
  end

  assign a_row = {a_vox, a_rd};

  // stage b payload and plane line read
  always_ff @(posedge clk) begin
    if (go && a_valid) begin
      b_row <= a_row;
      b_tag <= a_tag;
      b_ptr <= {a_pj, a_pk};
      b_rd  <= plane_mem[{a_pj, a_pk}];
    end
  end

  // plane line write
  always_ff @(posedge clk) begin
    if (go && b_valid) begin
      plane_mem[b_ptr] <= {b_row, b_rd[5:3]};
    end
  end

  assign b_col = {b_row, b_rd};

  // column shift, col[2] newest
  always_ff @(posedge clk) begin
    if (go && b_valid) begin
      col[2] <= b_col;
      col[1] <= col[2];
      col[0] <= col[1];
      c_tag  <= b_tag;
    end
  end

  assign win_valid = c_valid;
  assign win_tag   = c_tag;
  assign window    = {col[2], col[1], col[0]};

endmodule

FILE: sim/tb_voxel_surface_extract_26.sv
`timescale 1ns / 1ps
// testbench for voxel_surface_extract_26: streams occupancy volumes, checks every hull result
// depends on vse_pkg and the voxel_surface_extract_26 rtl

module tb_voxel_surface_extract_26;

  localparam int HALF_PERIOD = 6;
  localparam int RAND_ITEMS = 550;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 3000;
  localparam int MAP_DEPTH =
    vse_pkg::DEF_MAX_SIZE * vse_pkg::DEF_MAX_SIZE * vse_pkg::DEF_MAX_SIZE;

  // hull predictor with its own copy of the volume, plus the queue of pending results
  class hull_scoreboard;
    bit                          occ_map [MAP_DEPTH];
    logic [vse_pkg::GRID_W-1:0]  grid;
    int unsigned                 in_pos;
    int unsigned                 out_pos;
    logic [vse_pkg::COUNT_W-1:0] hull_total;
    vse_pkg::vse_result_t        results [$];
    int                          errors;

    function new();
      grid = vse_pkg::GRID_W'(vse_pkg::GRID_RESET);
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_pos = 0;
      out_pos = 0;
      hull_total = '0;
    endfunction

    // side in use, register value clamped
    function int unsigned side();
      if (grid < vse_pkg::MIN_SIZE) return vse_pkg::MIN_SIZE;
      if (grid > vse_pkg::DEF_MAX_SIZE) return vse_pkg::DEF_MAX_SIZE;
      return 32'(grid);
    endfunction

    function void write_size(logic [vse_pkg::GRID_W-1:0] value);
      grid = value;
      restart();
    endfunction

    // outside the volume reads as empty
    function bit occupied_at(int n, int i, int j, int k);
      if (i < 0 || j < 0 || k < 0 || i >= n || j >= n || k >= n) return 1'b0;
      return occ_map[(i * n + j) * n + k];
    endfunction

    // hull test of the voxel at the output position
    function void emit_result(int unsigned n);
      vse_pkg::vse_result_t r;
      int          i, j, k, di, dj, dk;
      int unsigned p;
      bit          hull;
      p = out_pos;
      i = p / (n * n);
      j = (p / n) % n;
      k = p % n;
      hull = 1'b0;
      if (occupied_at(n, i, j, k)) begin
        for (di = -1; di <= 1; di++) begin
          for (dj = -1; dj <= 1; dj++) begin
            for (dk = -1; dk <= 1; dk++) begin
              if ((di != 0 || dj != 0 || dk != 0) && !occupied_at(n, i + di, j + dj, k + dk))
                hull = 1'b1;
            end
          end
        end
      end
      if (hull) hull_total = hull_total + 1'b1;
      r.hull = hull;
      r.last = (p == n * n * n - 1);
      r.count = hull_total;
      results.push_back(r);
      out_pos = p + 1;
      if (r.last) restart();
    endfunction

    // one accepted request
    function void note_request(logic occ, logic fl);
      int unsigned n, vol, lag;
      n = side();
      vol = n * n * n;
      lag = n * n + n + 1;
      if (!fl && in_pos < vol) begin
        occ_map[in_pos] = occ;
        in_pos++;
        if (in_pos - 1 >= out_pos + lag) emit_result(n);
      end else if (in_pos >= vol && out_pos < vol) begin
        emit_result(n);
      end
    endfunction

    // volume fully received, results still owed
    function bit draining();
      int unsigned vol;
      vol = side() * side() * side();
      return in_pos >= vol && out_pos < vol;
    endfunction

    function int pending();
      return results.size();
    endfunction

    function void check_result(logic h, logic l, logic [vse_pkg::COUNT_W-1:0] c);
      vse_pkg::vse_result_t want;
      if (results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result is_hull %b is_last %b hull_count %0d", $time, h, l, c);
        return;
      end
      want = results.pop_front();
      if (h !== want.hull) begin
        errors++;
        $display("%0t: is_hull expected %b actual %b", $time, want.hull, h);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: is_last expected %b actual %b", $time, want.last, l);
      end
      if (c !== want.count) begin
        errors++;
        $display("%0t: hull_count expected %0d actual %0d", $time, want.count, c);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_wen;
  logic [vse_pkg::GRID_W-1:0]  cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic                        occupied;
  logic                        flush;
  logic                        out_valid;
  logic                        out_stall;
  logic                        is_hull;
  logic                        is_last;
  logic [vse_pkg::COUNT_W-1:0] hull_count;

  hull_scoreboard sb;
  logic           quiet;
  logic           hold_req;
  int             items;
  int             stuck_cycles;

  voxel_surface_extract_26 u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .occupied   (occupied),
    .flush      (flush),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_hull    (is_hull),
    .is_last    (is_last),
    .hull_count (hull_count)
  );

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // offer one request after a random gap, return at the falling edge after it is taken
  task automatic send_request(input logic occ, input logic fl);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    occupied = occ;
    flush = fl;
    do @(posedge clk); while (in_stall);
    sb.note_request(occ, fl);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // size write once all results are in and the pipeline has settled
  task automatic set_size(input logic [vse_pkg::GRID_W-1:0] value);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = value;
    cfg_wen = 1'b1;
    @(negedge clk);
    cfg_wen = 1'b0;
    sb.write_size(value);
  endtask

  // result side: random stall before each result, one long hold-off on request
  initial begin : result_sink
    int hold;
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(is_hull, is_last, hull_count);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int n, density, stop_at, vol, phase_no, d;
    bit cut;
    sb = new();
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    occupied = 1'b0;
    flush = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // largest side, a flush before the volume is complete, then abort by a write
    set_size(vse_pkg::GRID_W'(vse_pkg::DEF_MAX_SIZE));
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    // register above the largest side, then below the smallest
    set_size(7'h7f);
    send_request(1'b1, 1'b0);
    set_size(7'd2);
    // solid smallest cube, early flush inside, drained by flushes and excess voxels
    for (int v = 0; v < 27; v++) begin
      if (v == 5) send_request(1'b1, 1'b1);
      send_request(1'b1, 1'b0);
    end
    d = 0;
    while (sb.draining()) begin
      case (d % 3)
        0: send_request(1'b0, 1'b1);
        1: send_request(1'b1, 1'b0);
        default: send_request(1'b0, 1'b0);
      endcase
      d++;
    end
    // flush with nothing left to drain
    send_request(1'b1, 1'b1);

    // random volumes
    phase_no = 0;
    while (items < RAND_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (phase_no != 1 && $urandom_range(0, 9) == 0) begin
        // register value at or above the largest side, a few voxels, aborted by the next write
        set_size(vse_pkg::GRID_W'($urandom_range(vse_pkg::DEF_MAX_SIZE, 127)));
        repeat ($urandom_range(1, 20)) begin
          send_request(1'($urandom_range(0, 1)), 1'b0);
          items++;
        end
      end else begin
        if (phase_no == 1) begin
          // fill the block while the receiver holds off
          set_size(7'd5);
          hold_req = 1'b1;
          quiet = 1'b1;
          density = 90;
          cut = 1'b0;
        end else begin
          set_size(vse_pkg::GRID_W'($urandom_range(0, 5)));
          case ($urandom_range(0, 4))
            0: density = 0;
            1: density = 35;
            2: density = 70;
            3: density = 92;
            default: density = 100;
          endcase
          cut = ($urandom_range(0, 7) == 0);
        end
        n = sb.side();
        vol = n * n * n;
        stop_at = cut ? $urandom_range(1, vol - 1) : vol;
        for (int v = 0; v < stop_at; v++) begin
          if ($urandom_range(0, 11) == 0) send_request(1'($urandom_range(0, 1)), 1'b1);
          send_request($urandom_range(0, 99) < density, 1'b0);
          items++;
        end
        while (sb.draining()) begin
          if ($urandom_range(0, 3) == 0) send_request(1'($urandom_range(0, 1)), 1'b0);
          else send_request(1'($urandom_range(0, 1)), 1'b1);
          items++;
        end
      end
      phase_no++;
    end

    // wait for the last results and a quiet tail
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
